// ----- rtl/qvou_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvou_pkg
// Types, constants and helpers shared by the q-voter opinion update unit.
// ----------------------------------------------------------------------------
package qvou_pkg;

    localparam int AGENTS_DEF    = 65536;
    localparam int MAX_GROUP_DEF = 4;
    localparam int FIELD_LIMIT   = 4;

    localparam int IDX_W     = 16;
    localparam int DRAW_W    = 16;
    localparam int RATE_W    = 17;
    localparam int CNT_W     = 17;
    localparam int GRP_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_W    = 3;

    localparam logic [GRP_W-1:0]  GROUP_SIZE_RST   = 3'd3;
    localparam logic [RATE_W-1:0] PRIVATE_RATE_RST = 17'd6554;
    localparam logic [RATE_W-1:0] INDEP_RATE_RST   = 17'd0;
    localparam logic [RATE_W-1:0] FLIP_RATE_RST    = 17'd32768;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // entry layout: bit 0 public, bit 1 private
    localparam logic [1:0] OPINION_RST = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROUP_SIZE   = 2'd0,
        CFG_PRIVATE_RATE = 2'd1,
        CFG_INDEP_RATE   = 2'd2,
        CFG_FLIP_RATE    = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  agent;
        logic [IDX_W-1:0]  neighbour_a;
        logic [IDX_W-1:0]  neighbour_b;
        logic [IDX_W-1:0]  neighbour_c;
        logic [IDX_W-1:0]  neighbour_d;
        logic [DRAW_W-1:0] kind_draw;
        logic [DRAW_W-1:0] independence_draw;
        logic [DRAW_W-1:0] flip_draw;
        logic              load_public;
        logic              load_private;
    } t_in_item;

    typedef struct packed {
        logic             agent_public;
        logic             agent_private;
        logic [CNT_W-1:0] public_positive_count;
        logic [CNT_W-1:0] private_positive_count;
        logic [CNT_W-1:0] dissonant_count;
    } t_out_item;

    typedef struct packed {
        logic [GRP_W-1:0]  group_size;
        logic [RATE_W-1:0] private_rate;
        logic [RATE_W-1:0] independence_rate;
        logic [RATE_W-1:0] flip_rate;
    } t_cfg;

    function automatic logic [GRP_W-1:0] f_eff_group(
        input logic [GRP_W-1:0] g,
        input logic [GRP_W-1:0] lim
    );
        logic [GRP_W-1:0] r;
        r = g;
        if (r == '0) begin
            r = GRP_W'(1);
        end
        if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

endpackage

// ----- rtl/qvou_decide.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvou_decide
// Opinion rule: new public and private bits of one agent from its current
// bits, the public bits of its neighbours and the three draws.
// ----------------------------------------------------------------------------
module qvou_decide (
    input  logic [1:0]                             i_bits,
    input  logic [qvou_pkg::FIELD_LIMIT-1:0]       i_nb_pub,
    input  logic [qvou_pkg::GRP_W-1:0]             i_group,
    input  qvou_pkg::t_cfg                         i_cfg,
    input  qvou_pkg::t_in_item                     i_item,
    output logic [1:0]                             o_bits
);

    logic pub;
    logic priv;
    logic unanimous;
    logic any_match;
    logic kind_public;
    logic indep;
    logic flip;

    always_comb begin
        unanimous = 1'b1;
        any_match = 1'b0;
        for (int i = 0; i < qvou_pkg::FIELD_LIMIT; i++) begin
            if (qvou_pkg::GRP_W'(i) < i_group) begin
                if (i_nb_pub[i] != i_nb_pub[0]) begin
                    unanimous = 1'b0;
                end
                if (i_nb_pub[i] == i_bits[1]) begin
                    any_match = 1'b1;
                end
            end
        end
    end

    assign kind_public = {1'b0, i_item.kind_draw} > i_cfg.private_rate;
    assign indep       = {1'b0, i_item.independence_draw} < i_cfg.independence_rate;
    assign flip        = {1'b0, i_item.flip_draw} < i_cfg.flip_rate;

    always_comb begin
        pub  = i_bits[0];
        priv = i_bits[1];
        if (kind_public) begin
            if (indep) begin
                pub = priv;
            end else if (pub != priv) begin
                if (any_match) begin
                    pub = priv;
                end
            end else if (unanimous) begin
                pub = i_nb_pub[0];
            end
        end else begin
            if (indep) begin
                if (flip) begin
                    priv = ~priv;
                end
            end else if (unanimous) begin
                priv = i_nb_pub[0];
            end
        end
        o_bits = {priv, pub};
    end

endmodule

// ----- rtl/q_voter_opinion_update_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_voter_opinion_update_unit
// Agent opinion store with public/private bits, running tallies and the
// q-voter update with independence, compliance and disinhibitory contagion.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+------------------------
//  in       | input     | i_in_valid / o_in_ready   | t_in_item
//  out      | output    | o_out_valid / i_out_ready | t_out_item
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  an update reads the agent entry, then its q neighbour entries (q = group
//  size), through the single read port of the opinion memory, one entry per cycle
//  a load, or an update with a consulted neighbour out of range, reads only
//  the agent entry, and an out-of-range agent skips the reads
//  after reset a clearing pass writes every entry before the first beat is
//  taken; cfg writes are taken throughout
//  a stalled result holds the write-back cycle until the out register frees
// ----------------------------------------------------------------------------
module q_voter_opinion_update_unit #(
    parameter int AGENTS    = qvou_pkg::AGENTS_DEF,
    parameter int MAX_GROUP = qvou_pkg::MAX_GROUP_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  qvou_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output qvou_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qvou_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [qvou_pkg::RATE_W-1:0]       i_cfg_data
);

    localparam int AW    = $clog2(AGENTS);
    localparam int TW    = $clog2(AGENTS + 1);
    localparam int EXT_W = ((AW > qvou_pkg::IDX_W) ? AW : qvou_pkg::IDX_W) + 1;
    localparam int GLIM  = (MAX_GROUP < qvou_pkg::FIELD_LIMIT) ? MAX_GROUP
                                                              : qvou_pkg::FIELD_LIMIT;
    localparam int NSLOT = qvou_pkg::FIELD_LIMIT + 1;

    function automatic logic f_in_range(input logic [qvou_pkg::IDX_W-1:0] x);
        return EXT_W'(x) < EXT_W'(AGENTS);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [qvou_pkg::IDX_W-1:0] x);
        logic [EXT_W-1:0] e;
        e = EXT_W'(x);
        return e[AW-1:0];
    endfunction

    logic [1:0] r_mem [AGENTS];
    logic [1:0] r_rdata;

    qvou_pkg::t_state   r_state;
    qvou_pkg::t_state   n_state;
    qvou_pkg::t_cfg     r_cfg;
    qvou_pkg::t_in_item r_item;
    qvou_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_addrs [NSLOT];
    logic [qvou_pkg::SLOT_W-1:0] r_slot;
    logic [qvou_pkg::SLOT_W-1:0] r_last;
    logic [qvou_pkg::SLOT_W-1:0] r_rd_slot;
    logic               r_rd_vld;
    logic               r_in_range;
    logic               r_nb_bad;
    logic [qvou_pkg::GRP_W-1:0]  r_q;
    logic [1:0]         r_agent_bits;
    logic [qvou_pkg::FIELD_LIMIT-1:0] r_nb_pub;

    logic [TW-1:0]      r_pub_cnt;
    logic [TW-1:0]      r_priv_cnt;
    logic [TW-1:0]      r_dis_cnt;
    logic [TW-1:0]      n_pub_cnt;
    logic [TW-1:0]      n_priv_cnt;
    logic [TW-1:0]      n_dis_cnt;

    logic               in_ready;
    logic               in_accept;
    logic               exec_go;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [1:0]         mem_wd;
    logic [AW-1:0]      rd_addr;
    logic [qvou_pkg::GRP_W-1:0] q_eff;
    logic               nb_bad;
    logic [qvou_pkg::IDX_W-1:0] nb_idx [qvou_pkg::FIELD_LIMIT];
    logic [1:0]         dec_bits;
    logic [1:0]         wr_bits;
    logic [qvou_pkg::SLOT_W-1:0] nb_sel;

    assign q_eff = qvou_pkg::f_eff_group(r_cfg.group_size, qvou_pkg::GRP_W'(GLIM));

    assign nb_idx[0] = i_in_item.neighbour_a;
    assign nb_idx[1] = i_in_item.neighbour_b;
    assign nb_idx[2] = i_in_item.neighbour_c;
    assign nb_idx[3] = i_in_item.neighbour_d;

    always_comb begin
        nb_bad = 1'b0;
        for (int i = 0; i < qvou_pkg::FIELD_LIMIT; i++) begin
            if (qvou_pkg::GRP_W'(i) < q_eff && !f_in_range(nb_idx[i])) begin
                nb_bad = 1'b1;
            end
        end
    end

    qvou_decide u_decide (
        .i_bits   (r_agent_bits),
        .i_nb_pub (r_nb_pub),
        .i_group  (r_q),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_bits   (dec_bits)
    );

    always_comb begin
        if (r_item.action == qvou_pkg::ACT_LOAD) begin
            wr_bits = {r_item.load_private, r_item.load_public};
        end else if (r_nb_bad) begin
            wr_bits = r_agent_bits;
        end else begin
            wr_bits = dec_bits;
        end
    end

    always_comb begin
        n_pub_cnt  = r_pub_cnt;
        n_priv_cnt = r_priv_cnt;
        n_dis_cnt  = r_dis_cnt;
        if (r_in_range) begin
            n_pub_cnt  = r_pub_cnt - TW'(r_agent_bits[0]) + TW'(wr_bits[0]);
            n_priv_cnt = r_priv_cnt - TW'(r_agent_bits[1]) + TW'(wr_bits[1]);
            n_dis_cnt  = r_dis_cnt - TW'(r_agent_bits[0] ^ r_agent_bits[1])
                         + TW'(wr_bits[0] ^ wr_bits[1]);
        end
    end

    assign rd_addr = r_addrs[r_slot];
    assign exec_go = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_addrs[0];
        mem_wd   = wr_bits;
        case (r_state)
            qvou_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = qvou_pkg::OPINION_RST;
                if (r_clr == AW'(AGENTS - 1)) begin
                    n_state = qvou_pkg::S_IDLE;
                end
            end
            qvou_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = f_in_range(i_in_item.agent) ? qvou_pkg::S_READ
                                                          : qvou_pkg::S_EXEC;
                end
            end
            qvou_pkg::S_READ: begin
                if (r_slot == r_last) begin
                    n_state = qvou_pkg::S_WAIT;
                end
            end
            qvou_pkg::S_WAIT: begin
                n_state = qvou_pkg::S_EXEC;
            end
            qvou_pkg::S_EXEC: begin
                if (exec_go) begin
                    mem_we  = r_in_range;
                    n_state = qvou_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qvou_pkg::S_IDLE;
            end
        endcase
    end

    assign in_accept = in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qvou_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_slot      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_pub_cnt   <= TW'(AGENTS);
            r_priv_cnt  <= TW'(AGENTS);
            r_dis_cnt   <= '0;
            r_cfg.group_size        <= qvou_pkg::GROUP_SIZE_RST;
            r_cfg.private_rate      <= qvou_pkg::PRIVATE_RATE_RST;
            r_cfg.independence_rate <= qvou_pkg::INDEP_RATE_RST;
            r_cfg.flip_rate         <= qvou_pkg::FLIP_RATE_RST;
        end else begin
            if (r_state == qvou_pkg::S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (in_accept) begin
                r_slot <= '0;
            end else if (r_state == qvou_pkg::S_READ) begin
                r_slot <= r_slot + qvou_pkg::SLOT_W'(1);
            end
            r_rd_vld <= (r_state == qvou_pkg::S_READ);
            if (r_state == qvou_pkg::S_EXEC && exec_go) begin
                r_out_valid <= 1'b1;
                r_pub_cnt   <= n_pub_cnt;
                r_priv_cnt  <= n_priv_cnt;
                r_dis_cnt   <= n_dis_cnt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (qvou_pkg::t_cfg_reg'(i_cfg_index))
                    qvou_pkg::CFG_GROUP_SIZE:   r_cfg.group_size <= i_cfg_data[2:0];
                    qvou_pkg::CFG_PRIVATE_RATE: r_cfg.private_rate <= i_cfg_data;
                    qvou_pkg::CFG_INDEP_RATE:   r_cfg.independence_rate <= i_cfg_data;
                    qvou_pkg::CFG_FLIP_RATE:    r_cfg.flip_rate <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign nb_sel = r_rd_slot - qvou_pkg::SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        r_rd_slot <= r_slot;
        if (in_accept) begin
            r_item     <= i_in_item;
            r_in_range <= f_in_range(i_in_item.agent);
            r_nb_bad   <= nb_bad;
            r_q        <= q_eff;
            r_addrs[0] <= f_addr(i_in_item.agent);
            for (int i = 0; i < qvou_pkg::FIELD_LIMIT; i++) begin
                r_addrs[i+1] <= f_addr(nb_idx[i]);
            end
            if (i_in_item.action == qvou_pkg::ACT_LOAD || nb_bad) begin
                r_last <= '0;
            end else begin
                r_last <= qvou_pkg::SLOT_W'(q_eff);
            end
        end
        if (r_rd_vld) begin
            if (r_rd_slot == '0) begin
                r_agent_bits <= r_rdata;
            end else begin
                r_nb_pub[nb_sel[1:0]] <= r_rdata[0];
            end
        end
        if (r_state == qvou_pkg::S_EXEC && exec_go) begin
            r_out.agent_public           <= r_in_range & wr_bits[0];
            r_out.agent_private          <= r_in_range & wr_bits[1];
            r_out.public_positive_count  <= qvou_pkg::CNT_W'(n_pub_cnt);
            r_out.private_positive_count <= qvou_pkg::CNT_W'(n_priv_cnt);
            r_out.dissonant_count        <= qvou_pkg::CNT_W'(n_dis_cnt);
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qvou_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("item accepted during clearing pass");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qvou_pkg::S_READ || r_state == qvou_pkg::S_WAIT) |-> !mem_we)
        else $error("memory written while gathering reads");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qvou_pkg::S_EXEC && exec_go) |=> o_out_valid)
        else $error("write-back without result");

    a_dissonance_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dis_cnt <= TW'(AGENTS))
        else $error("dissonance tally above agent count");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the q-voter opinion update unit. A shadow copy of
// the opinion store, the tallies and the registers predicts every result
// beat: short directed runs cover loads, public and private updates,
// independence, contagion, compliance and the register extremes. Randomized
// phases then run interacting agents under changing settings, with random
// idle cycles on both channels in all phases but one.
// ----------------------------------------------------------------------------
module tb;
    import qvou_pkg::*;

    localparam int GROUP_CAP   = (MAX_GROUP_DEF < FIELD_LIMIT) ? MAX_GROUP_DEF : FIELD_LIMIT;
    localparam int POOL        = 24;
    localparam int PHASE_ITEMS = 160;
    localparam int STALL_LIMIT = 4 * AGENTS_DEF;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    t_cfg_reg   cfg_index = CFG_GROUP_SIZE;
    logic [RATE_W-1:0] cfg_data = '0;

    // shadow state
    logic [1:0]        shadow_op [AGENTS_DEF];
    int unsigned       tally_pub = AGENTS_DEF;
    int unsigned       tally_priv = AGENTS_DEF;
    int unsigned       tally_dis = 0;
    logic [GRP_W-1:0]  grp_size = GROUP_SIZE_RST;
    logic [RATE_W-1:0] alpha_rate = PRIVATE_RATE_RST;
    logic [RATE_W-1:0] indep_rate = INDEP_RATE_RST;
    logic [RATE_W-1:0] flip_rate = FLIP_RATE_RST;

    t_out_item opinion_expect_q [$];
    int        err_count = 0;
    int        quiet_cycles = 0;
    bit        idle_en = 1'b1;

    q_voter_opinion_update_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic t_out_item predict_opinion(input t_in_item it);
        t_out_item   r;
        logic [1:0]  prev;
        logic [1:0]  ent;
        logic        pub;
        logic        priv;
        logic        unan;
        logic        nb_pub [FIELD_LIMIT];
        logic [IDX_W-1:0] nb_idx [FIELD_LIMIT];
        int          q;
        nb_idx = '{it.neighbour_a, it.neighbour_b, it.neighbour_c, it.neighbour_d};
        q = int'(grp_size);
        if (q < 1) q = 1;
        if (q > GROUP_CAP) q = GROUP_CAP;
        prev = shadow_op[it.agent];
        ent = prev;
        if (it.action == ACT_LOAD) begin
            ent = {it.load_private, it.load_public};
        end else begin
            pub = prev[0];
            priv = prev[1];
            for (int i = 0; i < q; i++) nb_pub[i] = shadow_op[nb_idx[i]][0];
            unan = 1'b1;
            for (int i = 1; i < q; i++) if (nb_pub[i] != nb_pub[0]) unan = 1'b0;
            if ({1'b0, it.kind_draw} > alpha_rate) begin
                if ({1'b0, it.independence_draw} < indep_rate) begin
                    pub = priv;
                end else if (pub != priv) begin
                    for (int i = 0; i < q; i++) if (nb_pub[i] == priv) pub = priv;
                end else if (unan) begin
                    pub = nb_pub[0];
                end
            end else begin
                if ({1'b0, it.independence_draw} < indep_rate) begin
                    if ({1'b0, it.flip_draw} < flip_rate) priv = ~priv;
                end else if (unan) begin
                    priv = nb_pub[0];
                end
            end
            ent = {priv, pub};
        end
        shadow_op[it.agent] = ent;
        tally_pub  = tally_pub  - prev[0] + ent[0];
        tally_priv = tally_priv - prev[1] + ent[1];
        tally_dis  = tally_dis  - (prev[0] ^ prev[1]) + (ent[0] ^ ent[1]);
        r.agent_public           = ent[0];
        r.agent_private          = ent[1];
        r.public_positive_count  = CNT_W'(tally_pub);
        r.private_positive_count = CNT_W'(tally_priv);
        r.dissonant_count        = CNT_W'(tally_dis);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("tb: mismatch %s", msg);
    endtask

    task automatic send_item(input t_in_item it);
        while (idle_en && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        opinion_expect_q.insert(opinion_expect_q.size(), predict_opinion(it));
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (opinion_expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [RATE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_GROUP_SIZE:   grp_size   = data[GRP_W-1:0];
            CFG_PRIVATE_RATE: alpha_rate = data;
            CFG_INDEP_RATE:   indep_rate = data;
            CFG_FLIP_RATE:    flip_rate  = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [RATE_W-1:0] g, input logic [RATE_W-1:0] a,
                             input logic [RATE_W-1:0] p, input logic [RATE_W-1:0] f);
        write_reg(CFG_GROUP_SIZE, g);
        write_reg(CFG_PRIVATE_RATE, a);
        write_reg(CFG_INDEP_RATE, p);
        write_reg(CFG_FLIP_RATE, f);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item mk_load(input logic [IDX_W-1:0] agent,
                                         input logic pub, input logic priv);
        t_in_item it;
        it = '0;
        it.action       = ACT_LOAD;
        it.agent        = agent;
        it.load_public  = pub;
        it.load_private = priv;
        return it;
    endfunction

    function automatic t_in_item mk_update(input logic [IDX_W-1:0] agent,
                                           input logic [IDX_W-1:0] na, input logic [IDX_W-1:0] nb,
                                           input logic [IDX_W-1:0] nc, input logic [IDX_W-1:0] nd,
                                           input logic [DRAW_W-1:0] kind,
                                           input logic [DRAW_W-1:0] indep,
                                           input logic [DRAW_W-1:0] flip);
        t_in_item it;
        it = '0;
        it.action            = ACT_UPDATE;
        it.agent             = agent;
        it.neighbour_a       = na;
        it.neighbour_b       = nb;
        it.neighbour_c       = nc;
        it.neighbour_d       = nd;
        it.kind_draw         = kind;
        it.independence_draw = indep;
        it.flip_draw         = flip;
        return it;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(6))
            0:       return '0;
            1:       return RATE_W'(65536);
            2:       return RATE_W'(65535);
            3:       return RATE_W'($urandom_range(131071));
            default: return RATE_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw(input logic [RATE_W-1:0] rate);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2, 3:    return DRAW_W'(int'(rate[DRAW_W-1:0]) + int'($urandom_range(2)) - 1);
            default: return DRAW_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_in_item gen_item();
        t_in_item         it;
        logic [IDX_W-1:0] nb [FIELD_LIMIT];
        bit               clash;
        it.action       = ($urandom_range(99) < 70) ? ACT_UPDATE : ACT_LOAD;
        it.agent        = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(POOL - 1))
                                                    : IDX_W'($urandom_range(65535));
        it.load_public  = 1'($urandom_range(1));
        it.load_private = 1'($urandom_range(1));
        it.kind_draw         = pick_draw(alpha_rate);
        it.independence_draw = pick_draw(indep_rate);
        it.flip_draw         = pick_draw(flip_rate);
        if ($urandom_range(99) < 88) begin
            // distinct neighbours from the shared pool, agent excluded
            for (int k = 0; k < FIELD_LIMIT; k++) begin
                do begin
                    nb[k] = IDX_W'($urandom_range(POOL - 1));
                    clash = (nb[k] == it.agent);
                    for (int j = 0; j < k; j++) if (nb[j] == nb[k]) clash = 1'b1;
                end while (clash);
            end
            // unused slots get arbitrary indices
            for (int k = (grp_size == 0 ? 1 : grp_size); k < FIELD_LIMIT; k++) begin
                if ($urandom_range(1)) nb[k] = IDX_W'($urandom_range(65535));
            end
        end else begin
            for (int k = 0; k < FIELD_LIMIT; k++) begin
                case ($urandom_range(3))
                    0:       nb[k] = it.agent;
                    1:       nb[k] = (k == 0) ? IDX_W'($urandom_range(POOL - 1)) : nb[0];
                    default: nb[k] = IDX_W'($urandom_range(65535));
                endcase
            end
        end
        it.neighbour_a = nb[0];
        it.neighbour_b = nb[1];
        it.neighbour_c = nb[2];
        it.neighbour_d = nb[3];
        return it;
    endfunction

    // reset settings: group of three, mostly public updates, no independence
    task automatic test_reset_settings();
        send_item(mk_load(16'd0, 1'b0, 1'b1));
        send_item(mk_load(16'hFFFF, 1'b1, 1'b0));
        send_item(mk_load(16'd1, 1'b0, 1'b0));
        send_item(mk_load(16'd2, 1'b0, 1'b0));
        send_item(mk_load(16'd3, 1'b0, 1'b0));
        send_item(mk_update(16'd0, 16'd1, 16'd2, 16'd3, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0));
        send_item(mk_update(16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0));
        send_item(mk_update(16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd2, 16'hFFFF, 16'hFFFF, 16'd0));
        send_item(mk_update(16'd2, 16'd3, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(mk_update(16'd3, 16'd2, 16'd2, 16'd3, 16'd0, 16'd6554, 16'hFFFF, 16'hFFFF));
        wait_drain();
    endtask

    // group size zero acts as one, always independent, always flipping
    task automatic test_group_floor();
        configure(RATE_W'(0), RATE_W'(0), RATE_W'(65536), RATE_W'(65536));
        send_item(mk_update(16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd0, 16'hFFFF, 16'hFFFF));
        send_item(mk_update(16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3, 16'd1, 16'hFFFF, 16'hFFFF));
        send_item(mk_update(16'd2, 16'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0));
        wait_drain();
    endtask

    // group size above the cap acts as four, private updates only
    task automatic test_group_cap();
        configure(RATE_W'(7), RATE_W'(65536), RATE_W'(0), RATE_W'(0));
        send_item(mk_load(16'd4, 1'b1, 1'b1));
        send_item(mk_update(16'd5, 16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF, 16'd0, 16'd0));
        send_item(mk_update(16'd6, 16'd2, 16'd3, 16'd2, 16'd3, 16'hFFFF, 16'hFFFF, 16'd0));
        wait_drain();
    endtask

    // rates with upper bits set, flip threshold just below full scale
    task automatic test_rate_edges();
        configure(RATE_W'(4), RATE_W'(131071), RATE_W'(131071), RATE_W'(65535));
        send_item(mk_update(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(mk_update(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'hFFFF, 16'hFFFF, 16'hFFFE));
        wait_drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            configure({(RATE_W-GRP_W)'($urandom_range(16383)), GRP_W'($urandom_range(7))},
                      pick_rate(), pick_rate(), pick_rate());
            idle_en = (ph != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(gen_item());
            wait_drain();
        end
        idle_en = 1'b1;
    endtask

    always @(posedge clk) begin
        out_ready <= idle_en ? ($urandom_range(99) >= 20) : 1'b1;
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (opinion_expect_q.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = opinion_expect_q.pop_front();
                if (out_item.agent_public !== want.agent_public)
                    report_mismatch($sformatf("agent_public got %b exp %b",
                                              out_item.agent_public, want.agent_public));
                if (out_item.agent_private !== want.agent_private)
                    report_mismatch($sformatf("agent_private got %b exp %b",
                                              out_item.agent_private, want.agent_private));
                if (out_item.public_positive_count !== want.public_positive_count)
                    report_mismatch($sformatf("public_positive_count got %0d exp %0d",
                                              out_item.public_positive_count,
                                              want.public_positive_count));
                if (out_item.private_positive_count !== want.private_positive_count)
                    report_mismatch($sformatf("private_positive_count got %0d exp %0d",
                                              out_item.private_positive_count,
                                              want.private_positive_count));
                if (out_item.dissonant_count !== want.dissonant_count)
                    report_mismatch($sformatf("dissonant_count got %0d exp %0d",
                                              out_item.dissonant_count, want.dissonant_count));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        foreach (shadow_op[i]) shadow_op[i] = OPINION_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_settings();
        test_group_floor();
        test_group_cap();
        test_rate_edges();
        test_random_phases();
        repeat (20) @(posedge clk);
        if (err_count == 0 && opinion_expect_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
